FILE: rtl/meu_pkg.sv
// Shared constants, command/status structs and multiply-op codes for the
// modular exponentiation unit. No dependencies.
package meu_pkg;

  localparam int unsigned OpW     = 32;  // base, modulus, result width
  localparam int unsigned ExpW    = 32;  // exponent bits scanned
  localparam int unsigned MulCntW = $clog2(OpW);
  localparam int unsigned ExpCntW = (ExpW > 1) ? $clog2(ExpW) : 1;

  // What the shared multiply-reduce unit is asked to compute
  typedef enum logic [1:0] {
    MulReduce,  // 1 * base mod m, i.e. base mod m
    MulSquare,  // r * r mod m
    MulBase     // r * base mod m
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_e mul_op;
    logic    mul_step;
    logic    store_base;
    logic    store_res;
    logic    exp_shift;
    logic    set_one;
    logic    set_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic exp_bit;
  } dp_status_t;

endpackage

FILE: rtl/meu_datapath.sv
// Datapath: operand registers, exponent shifter and bit-serial
// shift-and-add modular multiplier. Depends on meu_pkg.
module meu_datapath (
  input  logic                              clk_i,
  input  meu_pkg::dp_cmd_t                  cmd_i,
  input  logic [meu_pkg::OpW-1:0]           base_i,
  input  logic [meu_pkg::ExpW-1:0]          exponent_i,
  input  logic [meu_pkg::OpW-1:0]           modulus_i,
  output meu_pkg::dp_status_t               status_o,
  output logic [meu_pkg::OpW-1:0]           power_mod_o
);
  import meu_pkg::*;

  logic [OpW-1:0]  base_q, mod_q, res_q, acc_q, mcand_q, mplier_q;
  logic [ExpW-1:0] exp_q;

  logic [OpW:0]    dbl_sum, dbl_red, add_sum, add_red;
  logic [OpW-1:0]  acc_dbl, acc_step;

  // one multiplier bit per cycle: acc = 2*acc (+ mcand) mod m
  always_comb begin
    dbl_sum  = {acc_q, 1'b0};
    dbl_red  = (dbl_sum >= {1'b0, mod_q}) ? dbl_sum - {1'b0, mod_q} : dbl_sum;
    acc_dbl  = dbl_red[OpW-1:0];
    add_sum  = {1'b0, acc_dbl} + {1'b0, mcand_q};
    add_red  = (add_sum >= {1'b0, mod_q}) ? add_sum - {1'b0, mod_q} : add_sum;
    acc_step = mplier_q[OpW-1] ? add_red[OpW-1:0] : acc_dbl;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      exp_q  <= exponent_i;
      mod_q  <= modulus_i;
    end
    if (cmd_i.exp_shift) begin
      exp_q <= exp_q << 1;
    end
    if (cmd_i.mul_start) begin
      acc_q <= '0;
      unique case (cmd_i.mul_op)
        MulSquare: begin
          mcand_q  <= res_q;
          mplier_q <= res_q;
        end
        MulBase: begin
          mcand_q  <= res_q;
          mplier_q <= base_q;
        end
        default: begin
          mcand_q  <= OpW'(1);
          mplier_q <= base_q;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      acc_q    <= acc_step;
      mplier_q <= mplier_q << 1;
    end
    if (cmd_i.store_base) begin
      base_q <= acc_q;
      res_q  <= (mod_q == OpW'(1)) ? '0 : OpW'(1);
    end
    if (cmd_i.store_res) begin
      res_q <= acc_q;
    end
    if (cmd_i.set_one) begin
      res_q <= OpW'(1);
    end
    if (cmd_i.set_zero) begin
      res_q <= '0;
    end
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.mod_zero = (mod_q == '0);
  assign status_o.exp_bit  = exp_q[ExpW-1];
  assign power_mod_o       = res_q;

endmodule

FILE: rtl/meu_ctrl.sv
// Controller: sequences the base reduction, squarings and multiplies
// over the exponent bits, and runs both handshakes. Depends on meu_pkg.
module meu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  meu_pkg::dp_status_t  status_i,
  output meu_pkg::dp_cmd_t     cmd_o
);
  import meu_pkg::*;

  typedef enum logic [2:0] {Idle, Check, Start, Mul, Post, Done} state_e;

  localparam logic [MulCntW-1:0] MulLast = MulCntW'(OpW - 1);
  localparam logic [ExpCntW-1:0] ExpLast = ExpCntW'(ExpW - 1);

  state_e              state_q, state_d;
  mul_op_e             op_q, op_d;
  logic [MulCntW-1:0]  mcnt_q, mcnt_d;
  logic [ExpCntW-1:0]  ecnt_q, ecnt_d;
  logic                out_valid_q, out_valid_d;
  logic                advance;

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_op = op_q;
    state_d     = state_q;
    op_d        = op_q;
    mcnt_d      = mcnt_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q;
    advance     = 1'b0;
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = Check;
        end
      end
      Check: begin
        if (status_i.exp_zero) begin
          cmd_o.set_one = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = Done;
        end else if (status_i.mod_zero) begin
          cmd_o.set_zero = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = Done;
        end else begin
          op_d    = MulReduce;
          state_d = Start;
        end
      end
      Start: begin
        cmd_o.mul_start = 1'b1;
        mcnt_d          = '0;
        state_d         = Mul;
      end
      Mul: begin
        cmd_o.mul_step = 1'b1;
        if (mcnt_q == MulLast) begin
          mcnt_d  = '0;
          state_d = Post;
        end else begin
          mcnt_d = mcnt_q + 1'b1;
        end
      end
      Post: begin
        unique case (op_q)
          MulReduce: begin
            cmd_o.store_base = 1'b1;
            ecnt_d           = '0;
            op_d             = MulSquare;
            state_d          = Start;
          end
          MulSquare: begin
            cmd_o.store_res = 1'b1;
            if (status_i.exp_bit) begin
              op_d    = MulBase;
              state_d = Start;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            cmd_o.store_res = 1'b1;
            advance         = 1'b1;
          end
        endcase
        if (advance) begin
          cmd_o.exp_shift = 1'b1;
          if (ecnt_q == ExpLast) begin
            out_valid_d = 1'b1;
            state_d     = Done;
          end else begin
            ecnt_d  = ecnt_q + 1'b1;
            op_d    = MulSquare;
            state_d = Start;
          end
        end
      end
      Done: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = Idle;
        end
      end
      default: begin
        out_valid_d = 1'b0;
        state_d     = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      op_q        <= MulReduce;
      mcnt_q      <= '0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      mcnt_q      <= mcnt_d;
      ecnt_q      <= ecnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != Idle);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_valid_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == Done)
    else $error("result valid outside Done");
  a_start_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> (state_q == Mul && mcnt_q == '0))
    else $error("multiply did not start at bit zero");
  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Mul && mcnt_q == MulLast) |=> state_q == Post)
    else $error("multiply ran past its last bit");
  a_res_write_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.store_base, cmd_o.store_res,
              cmd_o.set_one, cmd_o.set_zero}))
    else $error("conflicting register writes");
`endif

endmodule

FILE: rtl/modular_exponentiation_unit.sv
// Modular exponentiation, square-and-multiply, one item at a time.
// Each modular product is 32 steps on the one bit-serial multiply-reduce unit,
// plus a setup and a writeback state. Next item accepted once the result beat leaves.
// Reset (async, active low) returns the controller to idle; no data is cleared.
module modular_exponentiation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [meu_pkg::OpW-1:0]      base_i,
  input  logic [meu_pkg::ExpW-1:0]     exponent_i,
  input  logic [meu_pkg::OpW-1:0]      modulus_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [meu_pkg::OpW-1:0]      power_mod_o
);
  import meu_pkg::*;

  // Controller and datapath talk only through these two bundles.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: checks the special cases (exponent zero gives 1, modulus
  // zero gives 0), reduces the base, then walks the exponent MSB first with
  // a squaring per bit and a multiply by the base per set bit.
  meu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Operand registers and the shift-and-add multiply-reduce; the result
  // register holds the output beat steady while it is stalled.
  meu_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_i),
    .status_o    (status),
    .power_mod_o (power_mod_o)
  );

endmodule

FILE: dv/tb_modular_exponentiation_unit.sv
// Self-checking testbench for modular_exponentiation_unit: directed corner cases,
// receiver hold-off, sender pause and randomized operands checked against a
// square-and-multiply predictor. Depends on rtl/meu_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;
  import meu_pkg::*;

  // Limit is the worst beat, plus sender gap and receiver stall, for ~290 beats,
  // taken about four times over.
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 4000;
  localparam logic [OpW-1:0] OpMax = '1;
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic [OpW-1:0] PrimeMod = 32'd4294967291;  // largest 32-bit prime

  typedef struct {
    logic [OpW-1:0]  base;
    logic [ExpW-1:0] exponent;
    logic [OpW-1:0]  modulus;
    logic [OpW-1:0]  power_mod;
  } pending_power_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [OpW-1:0]  base_i;
  logic [ExpW-1:0] exponent_i;
  logic [OpW-1:0]  modulus_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [OpW-1:0]  power_mod_o;

  pending_power_t pending_powers[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    hold_request = 0;  // long receiver hold-off, picked up by the stall driver
  bit             idling_on = 1'b1;

  modular_exponentiation_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .power_mod_o (power_mod_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Square-and-multiply from the exponent MSB down. Operands stay below the
  // modulus, so every product fits the double-width accumulator exactly.
  function automatic logic [OpW-1:0] expected_power(input logic [OpW-1:0] b,
                                                    input logic [ExpW-1:0] e,
                                                    input logic [OpW-1:0] m);
    logic [2*OpW-1:0] acc;
    logic [2*OpW-1:0] base_red;
    logic [2*OpW-1:0] m_wide;
    if (e == '0) begin
      return OpW'(1);
    end
    if (m == '0) begin
      return '0;
    end
    m_wide = {{OpW{1'b0}}, m};
    base_red = {{OpW{1'b0}}, b} % m_wide;
    acc = (2*OpW)'(1) % m_wide;
    for (int i = ExpW - 1; i >= 0; i--) begin
      acc = (acc * acc) % m_wide;
      if (e[i]) begin
        acc = (acc * base_red) % m_wide;
      end
    end
    return acc[OpW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Offers one beat, optionally after a random gap, and returns right after the
  // edge that accepts it. Valid is left high so back-to-back beats never toggle it.
  task automatic send_request(input logic [OpW-1:0] b, input logic [ExpW-1:0] e,
                              input logic [OpW-1:0] m);
    int unsigned gap;
    pending_power_t item;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i <= b;
    exponent_i <= e;
    modulus_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    item.base = b;
    item.exponent = e;
    item.modulus = m;
    item.power_mod = expected_power(b, e, m);
    pending_powers.push_back(item);
  endtask

  // Exponent zero gives 1 for every modulus, modulus 1 included; exponent one
  // reduces the base.
  task automatic test_special_exponents();
    send_request(32'd0, '0, 32'd1);
    send_request(OpMax, '0, 32'd1);
    send_request($urandom, '0, OpMax);
    send_request($urandom, '0, 32'd2);
    send_request(OpMax, 1, 32'd1);
    send_request(OpMax, 1, OpMax);
    send_request(32'd5, 1, OpMax);
    send_request(OpMax, 1, 32'h8000_0000);
    send_request(32'd12345, 1, 32'd7);
  endtask

  task automatic test_operand_extremes();
    send_request(32'd0, ExpMax, OpMax);
    send_request(OpMax, ExpMax, OpMax);
    send_request(OpMax - 1, ExpMax, OpMax);
    send_request(OpMax, ExpMax, OpMax - 1);
    send_request(32'd2, 32'h8000_0000, OpMax);
    send_request(32'd2, ExpMax, 32'd1);
    send_request(32'd1, ExpMax, PrimeMod);
    send_request(PrimeMod, 32'd3, PrimeMod);      // base equal to modulus
    send_request(32'd3, PrimeMod - 1, PrimeMod);  // Fermat: gives 1
    send_request(OpMax, 32'h5555_5555, 32'h8000_0000);
    send_request(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Receiver sits on the next result while more beats are offered, so the
  // unit has to stall its input.
  task automatic test_receiver_hold();
    hold_request = HoldCycles;
    repeat (4) send_request($urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
  endtask

  // Sender drops valid and waits until every result is back before resuming.
  task automatic test_sender_pause();
    in_valid_i <= 1'b0;
    wait (pending_powers.size() == 0);
    @(posedge clk_i);
    repeat (3) send_request($urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
  endtask

  task automatic test_random(input int unsigned count);
    logic [OpW-1:0]  b;
    logic [ExpW-1:0] e;
    logic [OpW-1:0]  m;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       m = $urandom_range(1, 16);
        1:       m = OpMax - $urandom_range(0, 15);
        2:       m = 32'd1 << $urandom_range(0, OpW - 1);
        3:       m = PrimeMod;
        default: m = $urandom;
      endcase
      if (m == '0) m = 1;
      case ($urandom_range(0, 7))
        0:       b = '0;
        1:       b = OpMax;
        2:       b = m + $urandom_range(0, 3);
        3:       b = m - 1;
        4:       b = $urandom_range(0, 15);
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       e = $urandom_range(0, 15);
        1:       e = ExpMax;
        2:       e = 1 << $urandom_range(0, ExpW - 1);
        3:       e = m - 1;
        default: e = $urandom;
      endcase
      send_request(b, e, m);
    end
  endtask

  // Receiver stall driver: a requested long hold wins, otherwise random bursts while idling is on.
  initial begin : stall_driver
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left = 0;
    burst_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 9);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result beats are compared in order against the oldest expectation.
  initial begin : result_checker
    pending_power_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_powers.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", power_mod_o));
        end else begin
          want = pending_powers.pop_front();
          if (power_mod_o !== want.power_mod) begin
            report_mismatch($sformatf("%h ^ %h mod %h: power_mod %h, want %h", want.base,
                                      want.exponent, want.modulus, power_mod_o,
                                      want.power_mod));
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[modular_exponentiation_unit] ERROR");
    $finish;
  end

  initial begin : sequencer
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    base_i = '0;
    exponent_i = '0;
    modulus_i = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_exponents();
    test_operand_extremes();
    test_receiver_hold();
    test_sender_pause();
    test_random(220);
    // last stretch runs with no idling on either side
    idling_on = 1'b0;
    test_random(40);

    in_valid_i <= 1'b0;
    wait (pending_powers.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[modular_exponentiation_unit] OK");
    end else begin
      $display("[modular_exponentiation_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/meu_pkg.sv
rtl/meu_datapath.sv
rtl/meu_ctrl.sv
rtl/modular_exponentiation_unit.sv
dv/tb_modular_exponentiation_unit.sv
